@@ rtl/alc_pkg.sv @@
// Package for the affine layer compositor: command and selector codes,
// fixed-point constants, CORDIC arctangent table, channel conversions and
// the controller/datapath command and status structs. No dependencies.
package alc_pkg;

    // Parameter defaults for the top level
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_LAYERS = 4;

    // Request command codes
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_PARAM  = 2'd1;
    localparam logic [1:0] CMD_RENDER = 2'd2;

    // Transform parameter selectors
    localparam logic [2:0] SEL_SCALE_X  = 3'd0;
    localparam logic [2:0] SEL_SCALE_Y  = 3'd1;
    localparam logic [2:0] SEL_OFFSET_X = 3'd2;
    localparam logic [2:0] SEL_OFFSET_Y = 3'd3;
    localparam logic [2:0] SEL_ROTATION = 3'd4;
    localparam logic [2:0] SEL_OPACITY  = 3'd5;

    // Fixed point
    localparam logic [16:0] ONE16 = 17'd65536;
    localparam int Z_W = 27;
    localparam logic        [31:0]  DEG360_U = 32'd23592960;
    localparam logic signed [Z_W-1:0] DEG360 = 27'sd23592960;
    localparam logic signed [Z_W-1:0] DEG180 = 27'sd11796480;
    localparam logic signed [Z_W-1:0] DEG90  = 27'sd5898240;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam int CORDIC_STEPS = 16;
    localparam int REDUCE_STEPS = 7;
    localparam int STEP_W = 4;

    // Arctangent of 2^-i in Q16.16 degrees
    function automatic logic signed [Z_W-1:0] atan_deg(input logic [STEP_W-1:0] i);
        logic signed [Z_W-1:0] a;
        case (i)
            4'd0:    a = 27'sd2949120;
            4'd1:    a = 27'sd1740967;
            4'd2:    a = 27'sd919879;
            4'd3:    a = 27'sd466945;
            4'd4:    a = 27'sd234379;
            4'd5:    a = 27'sd117304;
            4'd6:    a = 27'sd58666;
            4'd7:    a = 27'sd29335;
            4'd8:    a = 27'sd14668;
            4'd9:    a = 27'sd7334;
            4'd10:   a = 27'sd3667;
            4'd11:   a = 27'sd1833;
            4'd12:   a = 27'sd917;
            4'd13:   a = 27'sd458;
            4'd14:   a = 27'sd229;
            4'd15:   a = 27'sd115;
            default: a = '0;
        endcase
        return a;
    endfunction

    // 8-bit channel to Q1.16 with rounding: c*257 plus one for c >= 128
    function automatic logic [16:0] to_q16(input logic [7:0] c);
        return {1'b0, c, c} + 17'(c[7]);
    endfunction

    // Q1.16 back to 8 bits: min(v,1.0)*255 >> 16
    function automatic logic [7:0] to_byte(input logic [16:0] v);
        logic [16:0] m;
        logic [24:0] t;
        m = (v > ONE16) ? ONE16 : v;
        t = {m, 8'b0} - {8'b0, m};
        return t[23:16];
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic              capture;
        logic              load_wr;
        logic              param_wr;
        logic              rot_init;
        logic              red_step;
        logic              fold;
        logic              cordic_step;
        logic              rot_wr;
        logic              rnd_init;
        logic              uv;
        logic              rot;
        logic              sum;
        logic              mem_rd;
        logic              cov;
        logic              over;
        logic              blend;
        logic              next_layer;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       rot_sel;
        logic       layer_ok;
        logic       layers_done;
        logic       layer_on;
        logic       in_frame;
    } t_dp_status;

endpackage

@@ rtl/affine_layer_compositor.sv @@
// Top level of the affine layer compositor: controller plus datapath.
// Depends on alc_pkg, alc_ctrl and alc_datapath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------
//  input    | i_in_valid / o_in_stall   | i_cmd i_layer i_x i_y i_pixel
//           |                           | i_param_select i_param_value
//  output   | o_out_valid / i_out_stall | o_out_r o_out_g o_out_b o_out_a
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index i_cfg_data
//
// One request at a time. A load or plain parameter request is captured, then
// decoded and written; a rotation runs 7 reduce steps, a fold, 16 CORDIC steps
// and a store. A render checks each layer in the count in turn: a disabled
// layer is skipped, an enabled one is transformed, and only an in-frame sample
// is read from memory and blended. Layer memory is not cleared at reset.
// A finished result waits in the output register while the next request is
// taken; a render stalls only at its end if that register is still full.
module affine_layer_compositor #(
    parameter int MAX_WIDTH  = alc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = alc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_LAYERS = alc_pkg::DEF_MAX_LAYERS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic [1:0]         i_layer,
    input  logic [5:0]         i_x,
    input  logic [5:0]         i_y,
    input  logic [31:0]        i_pixel,
    input  logic [2:0]         i_param_select,
    input  logic signed [31:0] i_param_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_r,
    output logic [7:0]         o_out_g,
    output logic [7:0]         o_out_b,
    output logic [7:0]         o_out_a,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [6:0]         i_cfg_data
);
    import alc_pkg::*;

    t_dp_cmd    dp_ctl;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    alc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (dp_status),
        .o_ctl       (dp_ctl)
    );

    alc_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (dp_ctl),
        .o_status       (dp_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_layer        (i_layer),
        .i_x            (i_x),
        .i_y            (i_y),
        .i_pixel        (i_pixel),
        .i_param_select (i_param_select),
        .i_param_value  (i_param_value),
        .o_out_r        (o_out_r),
        .o_out_g        (o_out_g),
        .o_out_b        (o_out_b),
        .o_out_a        (o_out_a)
    );

    // An accepted request always holds off the next one
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted request");

    // Result register is loaded only when free or being drained
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctl.out_load |-> !(o_out_valid && i_out_stall))
        else $error("result overwritten while stalled");

    // A new result appears only after a render finish
    a_out_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(dp_ctl.out_load))
        else $error("result valid without render");

    // Memory reads only happen for in-frame samples
    a_rd_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_ctl.mem_rd |-> dp_status.in_frame)
        else $error("memory read out of frame");

endmodule

@@ rtl/alc_ctrl.sv @@
// Controller for the affine layer compositor: sequences loads, parameter
// writes, the rotation reduce/CORDIC passes and the per-layer render loop.
// Depends on alc_pkg.
module alc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  alc_pkg::t_dp_status i_status,
    output alc_pkg::t_dp_cmd    o_ctl
);
    import alc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_REDUCE, S_FOLD, S_CORDIC, S_ROT_WR,
        S_CHECK, S_UV, S_ROT, S_SUM, S_ADDR, S_COV, S_OVER, S_BLEND, S_FINISH
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              out_free;

    assign out_free    = !(r_out_valid && i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Next state and command decode
    always_comb begin
        o_ctl       = '0;
        o_ctl.step  = r_step;
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.cmd)
                    CMD_LOAD: begin
                        o_ctl.load_wr = 1'b1;
                        n_state       = S_IDLE;
                    end
                    CMD_PARAM: begin
                        if (i_status.rot_sel && i_status.layer_ok) begin
                            o_ctl.rot_init = 1'b1;
                            n_step         = STEP_W'(REDUCE_STEPS - 1);
                            n_state        = S_REDUCE;
                        end else begin
                            o_ctl.param_wr = 1'b1;
                            n_state        = S_IDLE;
                        end
                    end
                    CMD_RENDER: begin
                        o_ctl.rnd_init = 1'b1;
                        n_state        = S_CHECK;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_REDUCE: begin
                o_ctl.red_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_FOLD;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_FOLD: begin
                o_ctl.fold = 1'b1;
                n_step     = '0;
                n_state    = S_CORDIC;
            end
            S_CORDIC: begin
                o_ctl.cordic_step = 1'b1;
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_ROT_WR;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROT_WR: begin
                o_ctl.rot_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_CHECK: begin
                if (i_status.layers_done) begin
                    n_state = S_FINISH;
                end else if (i_status.layer_on) begin
                    n_state = S_UV;
                end else begin
                    o_ctl.next_layer = 1'b1;
                end
            end
            S_UV: begin
                o_ctl.uv = 1'b1;
                n_state  = S_ROT;
            end
            S_ROT: begin
                o_ctl.rot = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_ctl.sum = 1'b1;
                n_state   = S_ADDR;
            end
            S_ADDR: begin
                // out-of-frame samples are skipped
                if (i_status.in_frame) begin
                    o_ctl.mem_rd = 1'b1;
                    n_state      = S_COV;
                end else begin
                    o_ctl.next_layer = 1'b1;
                    n_state          = S_CHECK;
                end
            end
            S_COV: begin
                o_ctl.cov = 1'b1;
                n_state   = S_OVER;
            end
            S_OVER: begin
                o_ctl.over = 1'b1;
                n_state    = S_BLEND;
            end
            S_BLEND: begin
                o_ctl.blend      = 1'b1;
                o_ctl.next_layer = 1'b1;
                n_state          = S_CHECK;
            end
            S_FINISH: begin
                // wait until the output register is free
                if (out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ rtl/alc_datapath.sv @@
// Datapath for the affine layer compositor: configuration registers, layer
// pixel memory, transform parameters, rotation reduce and CORDIC, transform
// multipliers, coverage blend and output registers. Depends on alc_pkg.
module alc_datapath #(
    parameter int MAX_WIDTH  = alc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = alc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_LAYERS = alc_pkg::DEF_MAX_LAYERS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  alc_pkg::t_dp_cmd    i_ctl,
    output alc_pkg::t_dp_status o_status,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [6:0]          i_cfg_data,
    input  logic [1:0]          i_cmd,
    input  logic [1:0]          i_layer,
    input  logic [5:0]          i_x,
    input  logic [5:0]          i_y,
    input  logic [31:0]         i_pixel,
    input  logic [2:0]          i_param_select,
    input  logic signed [31:0]  i_param_value,
    output logic [7:0]          o_out_r,
    output logic [7:0]          o_out_g,
    output logic [7:0]          o_out_b,
    output logic [7:0]          o_out_a
);
    import alc_pkg::*;

    localparam int LAYER_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int DEPTH      = MAX_LAYERS * LAYER_SIZE;
    localparam int AW         = $clog2(DEPTH);
    localparam int LIW        = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int CW         = $clog2(MAX_LAYERS + 1);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int HW         = $clog2(MAX_HEIGHT + 1);

    localparam logic [1:0] CFG_LAYER_COUNT  = 2'd0;
    localparam logic [1:0] CFG_LAYER_ENABLE = 2'd1;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd3;

    // Configuration registers
    logic [2:0] r_layer_count;
    logic [3:0] r_layer_enable;
    logic [6:0] r_frame_width;
    logic [6:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count  <= 3'd0;
            r_layer_enable <= 4'd15;
            r_frame_width  <= 7'd64;
            r_frame_height <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LAYER_COUNT:  r_layer_count  <= i_cfg_data[2:0];
                CFG_LAYER_ENABLE: r_layer_enable <= i_cfg_data[3:0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped frame size and layer count
    logic [WW-1:0] w;
    logic [HW-1:0] h;
    logic [31:0]   n_layers;

    always_comb begin
        if (r_frame_width == '0) w = WW'(1);
        else if (32'(r_frame_width) > 32'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
        else w = WW'(r_frame_width);
        if (r_frame_height == '0) h = HW'(1);
        else if (32'(r_frame_height) > 32'(MAX_HEIGHT)) h = HW'(MAX_HEIGHT);
        else h = HW'(r_frame_height);
        n_layers = (32'(r_layer_count) > 32'(MAX_LAYERS)) ? 32'(MAX_LAYERS)
                                                           : 32'(r_layer_count);
    end

    // Captured request
    logic [1:0]         r_cmd;
    logic [1:0]         r_layer;
    logic [5:0]         r_x;
    logic [5:0]         r_y;
    logic [31:0]        r_pixel;
    logic [2:0]         r_sel;
    logic signed [31:0] r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd   <= i_cmd;
            r_layer <= i_layer;
            r_x     <= i_x;
            r_y     <= i_y;
            r_pixel <= i_pixel;
            r_sel   <= i_param_select;
            r_val   <= i_param_value;
        end
    end

    logic layer_ok;
    logic load_ok;
    assign layer_ok = (32'(r_layer) < 32'(MAX_LAYERS));
    assign load_ok  = layer_ok && (32'(r_x) < 32'(w)) && (32'(r_y) < 32'(h));

    // Rotation: modulo reduction, fold and CORDIC
    logic [31:0]            r_rem;
    logic                   r_neg;
    logic signed [Z_W-1:0]  r_z;
    logic                   r_flip;
    logic signed [32:0]     r_cx, r_cy;
    logic [31:0]            thr;
    logic signed [Z_W-1:0]  z0, z1, z2;
    logic signed [32:0]     sh_x, sh_y;
    logic signed [Z_W-1:0]  atan_i;
    logic signed [32:0]     fx, fy;
    logic signed [33:0]     tx, ty;
    logic signed [17:0]     qx, qy;
    logic signed [15:0]     cos_new, sin_new;

    always_comb begin
        thr    = DEG360_U << i_ctl.step;
        z0     = r_neg ? -$signed(r_rem[Z_W-1:0]) : $signed(r_rem[Z_W-1:0]);
        z1     = z0[Z_W-1] ? z0 + DEG360 : z0;
        z2     = (z1 > DEG180) ? z1 - DEG360 : z1;
        sh_x   = r_cx >>> i_ctl.step;
        sh_y   = r_cy >>> i_ctl.step;
        atan_i = atan_deg(i_ctl.step);
        fx     = r_flip ? -r_cx : r_cx;
        fy     = r_flip ? -r_cy : r_cy;
        tx     = {fx[32], fx} + 34'sd32768;
        ty     = {fy[32], fy} + 34'sd32768;
        qx     = tx[33:16];
        qy     = ty[33:16];
        if (qx > 18'sd32767) cos_new = 16'sd32767;
        else if (qx < -18'sd32768) cos_new = -16'sd32768;
        else cos_new = qx[15:0];
        if (qy > 18'sd32767) sin_new = 16'sd32767;
        else if (qy < -18'sd32768) sin_new = -16'sd32768;
        else sin_new = qy[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rot_init) begin
            r_neg <= r_val[31];
            r_rem <= r_val[31] ? 32'(-r_val) : 32'(r_val);
        end else if (i_ctl.red_step) begin
            if (r_rem >= thr) r_rem <= r_rem - thr;
        end
        if (i_ctl.fold) begin
            r_cx <= CORDIC_GAIN;
            r_cy <= '0;
            if (z2 > DEG90) begin
                r_z    <= z2 - DEG180;
                r_flip <= 1'b1;
            end else if (z2 < -DEG90) begin
                r_z    <= z2 + DEG180;
                r_flip <= 1'b1;
            end else begin
                r_z    <= z2;
                r_flip <= 1'b0;
            end
        end else if (i_ctl.cordic_step) begin
            if (!r_z[Z_W-1]) begin
                r_cx <= r_cx - sh_y;
                r_cy <= r_cy + sh_x;
                r_z  <= r_z - atan_i;
            end else begin
                r_cx <= r_cx + sh_y;
                r_cy <= r_cy - sh_x;
                r_z  <= r_z + atan_i;
            end
        end
    end

    // Per-layer transform parameters
    logic signed [31:0] r_scale_x  [MAX_LAYERS];
    logic signed [31:0] r_scale_y  [MAX_LAYERS];
    logic signed [31:0] r_offset_x [MAX_LAYERS];
    logic signed [31:0] r_offset_y [MAX_LAYERS];
    logic signed [15:0] r_cosine   [MAX_LAYERS];
    logic signed [15:0] r_sine     [MAX_LAYERS];
    logic signed [31:0] r_opacity  [MAX_LAYERS];
    logic [LIW-1:0]     wr_li;

    assign wr_li = LIW'(r_layer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_LAYERS; k++) begin
                r_scale_x[k]  <= 32'sh10000;
                r_scale_y[k]  <= 32'sh10000;
                r_offset_x[k] <= '0;
                r_offset_y[k] <= '0;
                r_cosine[k]   <= 16'sd16384;
                r_sine[k]     <= '0;
                r_opacity[k]  <= 32'sh10000;
            end
        end else if (i_ctl.param_wr && layer_ok) begin
            case (r_sel)
                SEL_SCALE_X:  r_scale_x[wr_li]  <= r_val;
                SEL_SCALE_Y:  r_scale_y[wr_li]  <= r_val;
                SEL_OFFSET_X: r_offset_x[wr_li] <= r_val;
                SEL_OFFSET_Y: r_offset_y[wr_li] <= r_val;
                SEL_OPACITY:  r_opacity[wr_li]  <= r_val;
                default: ;
            endcase
        end else if (i_ctl.rot_wr) begin
            r_cosine[wr_li] <= cos_new;
            r_sine[wr_li]   <= sin_new;
        end
    end

    // Render loop: layer counter and transform stages
    logic [CW-1:0]      r_li;
    logic [LIW-1:0]     li;
    logic signed [39:0] r_u, r_v;
    logic signed [55:0] r_uc, r_vs, r_us, r_vc;
    logic signed [26:0] r_sx, r_sy;
    logic signed [38:0] prod_u, prod_v;
    logic signed [56:0] sum_x, sum_y, tr_x, tr_y;
    logic               layer_on;
    logic               in_frame;

    assign li       = LIW'(r_li);
    assign layer_on = (32'(r_li) < 32'd4) ? r_layer_enable[2'(r_li)] : 1'b0;
    assign in_frame = !r_sx[26] && (r_sx < $signed(27'(w)))
                   && !r_sy[26] && (r_sy < $signed(27'(h)));

    always_comb begin
        prod_u = $signed({1'b0, r_x}) * r_scale_x[li];
        prod_v = $signed({1'b0, r_y}) * r_scale_y[li];
        sum_x  = {r_uc[55], r_uc} - {r_vs[55], r_vs};
        sum_y  = {r_us[55], r_us} + {r_vc[55], r_vc};
        // truncate toward zero on the >> 30
        tr_x   = sum_x + (sum_x[56] ? 57'sh3FFFFFFF : 57'sd0);
        tr_y   = sum_y + (sum_y[56] ? 57'sh3FFFFFFF : 57'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rnd_init) begin
            r_li <= '0;
        end else if (i_ctl.next_layer) begin
            r_li <= r_li + 1'b1;
        end
        if (i_ctl.uv) begin
            r_u <= {prod_u[38], prod_u} - {{8{r_offset_x[li][31]}}, r_offset_x[li]};
            r_v <= {prod_v[38], prod_v} - {{8{r_offset_y[li][31]}}, r_offset_y[li]};
        end
        if (i_ctl.rot) begin
            r_uc <= r_u * r_cosine[li];
            r_vs <= r_v * r_sine[li];
            r_us <= r_u * r_sine[li];
            r_vc <= r_v * r_cosine[li];
        end
        if (i_ctl.sum) begin
            r_sx <= tr_x[56:30];
            r_sy <= tr_y[56:30];
        end
    end

    // Layer pixel memory
    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd_data;
    logic [AW-1:0] wr_addr, rd_addr;

    assign wr_addr = AW'(r_layer) * AW'(LAYER_SIZE) + AW'(r_y) * AW'(w) + AW'(r_x);
    assign rd_addr = AW'(r_li) * AW'(LAYER_SIZE)
                   + AW'($unsigned(r_sy)) * AW'(w) + AW'($unsigned(r_sx));

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_wr && load_ok) r_mem[wr_addr] <= r_pixel;
        if (i_ctl.mem_rd) r_rd_data <= r_mem[rd_addr];
    end

    // Coverage and blend
    logic [16:0]        r_cov, r_over, r_cr, r_cg, r_cb;
    logic [16:0]        r_r, r_g, r_b, r_a;
    logic signed [31:0] opac;
    logic [47:0]        cov_prod;
    logic [33:0]        over_prod;
    logic [34:0]        mix_r, mix_g, mix_b;
    logic [33:0]        a_prod;

    always_comb begin
        opac      = r_opacity[li];
        cov_prod  = 48'(to_q16(r_rd_data[31:24])) * 48'(opac[30:0]);
        over_prod = 34'(r_cov) * 34'(ONE16 - r_a);
        mix_r     = 35'(r_cr) * 35'(r_over) + 35'(r_r) * 35'(ONE16 - r_over);
        mix_g     = 35'(r_cg) * 35'(r_over) + 35'(r_g) * 35'(ONE16 - r_over);
        mix_b     = 35'(r_cb) * 35'(r_over) + 35'(r_b) * 35'(ONE16 - r_over);
        a_prod    = 34'(r_a) * 34'(ONE16 - r_cov);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cov) begin
            r_cr <= to_q16(r_rd_data[7:0]);
            r_cg <= to_q16(r_rd_data[15:8]);
            r_cb <= to_q16(r_rd_data[23:16]);
            if (opac[31] || opac == '0) r_cov <= '0;
            else if (cov_prod[47:16] > 32'(ONE16)) r_cov <= ONE16;
            else r_cov <= cov_prod[32:16];
        end
        if (i_ctl.over) r_over <= over_prod[32:16];
        if (i_ctl.rnd_init) begin
            r_r <= '0;
            r_g <= '0;
            r_b <= '0;
            r_a <= '0;
        end else if (i_ctl.blend) begin
            r_r <= mix_r[32:16];
            r_g <= mix_g[32:16];
            r_b <= mix_b[32:16];
            r_a <= r_cov + a_prod[32:16];
        end
        if (i_ctl.out_load) begin
            o_out_r <= to_byte(r_r);
            o_out_g <= to_byte(r_g);
            o_out_b <= to_byte(r_b);
            o_out_a <= to_byte(r_a);
        end
    end

    // Status to controller
    assign o_status.cmd         = r_cmd;
    assign o_status.rot_sel     = (r_sel == SEL_ROTATION);
    assign o_status.layer_ok    = layer_ok;
    assign o_status.layers_done = (32'(r_li) >= n_layers);
    assign o_status.layer_on    = layer_on;
    assign o_status.in_frame    = in_frame;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for affine_layer_compositor: a queue-fed driver,
// a result monitor and a predictor of the layer compositing arithmetic.
// Depends on alc_pkg and the affine_layer_compositor RTL.
`timescale 1ns / 1ps

module tb_top;
    import alc_pkg::*;

    localparam int          LAYERS    = 4;
    localparam int          PLANE     = 64 * 64;
    localparam int          DRAIN_CYC = 200;
    localparam int          CYC_LIMIT = 2000000;
    localparam logic [1:0]  CMD_NOP   = 2'd3;
    localparam logic [2:0]  SEL_SPARE0 = 3'd6;
    localparam logic [2:0]  SEL_SPARE1 = 3'd7;
    localparam logic [1:0]  REG_COUNT  = 2'd0;
    localparam logic [1:0]  REG_ENABLE = 2'd1;
    localparam logic [1:0]  REG_WIDTH  = 2'd2;
    localparam logic [1:0]  REG_HEIGHT = 2'd3;
    localparam longint      Q_ONE      = 65536;
    localparam longint      ROT_360    = 360 * 65536;
    localparam longint      ROT_180    = 180 * 65536;
    localparam longint      ROT_90     = 90 * 65536;
    localparam longint      ROT_GAIN   = 652032874;
    localparam longint      ARCTAN [16] = '{2949120, 1740967, 919879, 466945, 234379,
        117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    typedef struct {
        logic [1:0]         cmd;
        logic [1:0]         layer;
        logic [5:0]         x;
        logic [5:0]         y;
        logic [31:0]        pixel;
        logic [2:0]         sel;
        logic signed [31:0] val;
    } req_t;

    typedef struct {
        logic [7:0] r, g, b, a;
    } rgba_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_cmd = '0;
    logic [1:0]         i_layer = '0;
    logic [5:0]         i_x = '0;
    logic [5:0]         i_y = '0;
    logic [31:0]        i_pixel = '0;
    logic [2:0]         i_param_select = '0;
    logic signed [31:0] i_param_value = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [7:0]         o_out_r, o_out_g, o_out_b, o_out_a;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [6:0]         i_cfg_data = '0;

    affine_layer_compositor u_dut (.*);

    always #6 i_clk = ~i_clk;

    // Pending requests and expected pixels
    req_t  req_q[$];
    rgba_t pixel_q[$];

    // Predictor copy of block state
    logic [31:0] pix_store [PLANE*LAYERS];
    bit          pix_written [PLANE*LAYERS];
    longint      sc_x[LAYERS], sc_y[LAYERS], of_x[LAYERS], of_y[LAYERS];
    longint      cos_q[LAYERS], sin_q[LAYERS], opac[LAYERS];
    int          cfg_count = 0, cfg_enable = 15, cfg_width = 64, cfg_height = 64;

    int  err_cnt = 0, n_req = 0, n_pix = 0, cycles = 0;
    int  idle_pct = 0, stall_pct = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    bit  in_took = 0;

    function automatic int frame_w();
        return cfg_width < 1 ? 1 : (cfg_width > 64 ? 64 : cfg_width);
    endfunction

    function automatic int frame_h();
        return cfg_height < 1 ? 1 : (cfg_height > 64 ? 64 : cfg_height);
    endfunction

    function automatic longint trunc_sh(longint v, int s);
        return v >= 0 ? (v >> s) : -((-v) >> s);
    endfunction

    function automatic longint sat14(longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic longint chan_q16(longint c);
        return (c * 65536 + 127) / 255;
    endfunction

    function automatic logic [7:0] chan_byte(longint v);
        if (v > Q_ONE) v = Q_ONE;
        return 8'((v * 255) >> 16);
    endfunction

    // Rotation to Q1.14 cosine/sine via fold and 16-step CORDIC
    task automatic set_angle(int li, longint deg);
        longint z, cx, cy, nx;
        bit flip;
        z = deg % ROT_360;
        cx = ROT_GAIN;
        cy = 0;
        flip = 0;
        if (z < 0) z += ROT_360;
        if (z > ROT_180) z -= ROT_360;
        if (z > ROT_90) begin
            z -= ROT_180;
            flip = 1;
        end else if (z < -ROT_90) begin
            z += ROT_180;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z -= ARCTAN[i];
            end else begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z += ARCTAN[i];
            end
            cx = nx;
        end
        if (flip) begin
            cx = -cx;
            cy = -cy;
        end
        cos_q[li] = sat14((cx + 32768) >>> 16);
        sin_q[li] = sat14((cy + 32768) >>> 16);
    endtask

    // Composite one output pixel; returns the first unwritten store address hit, else -1
    function automatic int composite(int px, int py, output rgba_t res);
        longint r, g, b, a, u, v, sx, sy, cov, over;
        int w, h, n, addr;
        logic [31:0] p;
        r = 0; g = 0; b = 0; a = 0;
        w = frame_w();
        h = frame_h();
        n = cfg_count > LAYERS ? LAYERS : cfg_count;
        res = '{default: 0};
        for (int i = 0; i < n; i++) begin
            if (!cfg_enable[i]) continue;
            u = longint'(px) * sc_x[i] - of_x[i];
            v = longint'(py) * sc_y[i] - of_y[i];
            sx = trunc_sh(u * cos_q[i] - v * sin_q[i], 30);
            sy = trunc_sh(u * sin_q[i] + v * cos_q[i], 30);
            if (sx < 0 || sx >= w || sy < 0 || sy >= h) continue;
            addr = i * PLANE + int'(sy) * w + int'(sx);
            if (!pix_written[addr]) return addr;
            p = pix_store[addr];
            if (opac[i] <= 0) cov = 0;
            else begin
                cov = (chan_q16(p[31:24]) * opac[i]) >> 16;
                if (cov > Q_ONE) cov = Q_ONE;
            end
            over = (cov * (Q_ONE - a)) >> 16;
            r = (chan_q16(p[7:0]) * over + r * (Q_ONE - over)) >> 16;
            g = (chan_q16(p[15:8]) * over + g * (Q_ONE - over)) >> 16;
            b = (chan_q16(p[23:16]) * over + b * (Q_ONE - over)) >> 16;
            a = cov + ((a * (Q_ONE - cov)) >> 16);
        end
        res.r = chan_byte(r);
        res.g = chan_byte(g);
        res.b = chan_byte(b);
        res.a = chan_byte(a);
        return -1;
    endfunction

    // Queue one request and update the predictor; renders first fill missing samples
    task automatic issue(req_t rq);
        rgba_t res;
        req_t ld;
        int m, w, off;
        w = frame_w();
        case (rq.cmd)
            CMD_LOAD: begin
                if (rq.x < w && rq.y < frame_h()) begin
                    pix_store[rq.layer*PLANE + rq.y*w + rq.x] = rq.pixel;
                    pix_written[rq.layer*PLANE + rq.y*w + rq.x] = 1;
                end
                req_q.push_back(rq);
            end
            CMD_PARAM: begin
                case (rq.sel)
                    SEL_SCALE_X:  sc_x[rq.layer] = rq.val;
                    SEL_SCALE_Y:  sc_y[rq.layer] = rq.val;
                    SEL_OFFSET_X: of_x[rq.layer] = rq.val;
                    SEL_OFFSET_Y: of_y[rq.layer] = rq.val;
                    SEL_ROTATION: set_angle(rq.layer, rq.val);
                    SEL_OPACITY:  opac[rq.layer] = rq.val;
                    default: ;
                endcase
                req_q.push_back(rq);
            end
            CMD_RENDER: begin
                forever begin
                    m = composite(rq.x, rq.y, res);
                    if (m < 0) break;
                    off = m % PLANE;
                    ld = '{cmd: CMD_LOAD, layer: 2'(m / PLANE), x: 6'(off % w),
                           y: 6'(off / w), pixel: $urandom, sel: 3'($urandom),
                           val: $urandom};
                    pix_store[m] = ld.pixel;
                    pix_written[m] = 1;
                    req_q.push_back(ld);
                end
                req_q.push_back(rq);
                pixel_q.push_back(res);
            end
            default: req_q.push_back(rq);
        endcase
    endtask

    function automatic logic signed [31:0] rand_value(logic [2:0] sel);
        if ($urandom_range(0, 4) == 0) return $urandom;
        case (sel)
            SEL_SCALE_X, SEL_SCALE_Y: return $urandom_range(16384, 131072);
            SEL_OFFSET_X, SEL_OFFSET_Y: return int'($urandom_range(0, 128*65536)) - 64*65536;
            SEL_ROTATION: return (int'($urandom_range(0, 720)) - 360) * 65536
                                 + int'($urandom_range(0, 65535));
            default: return int'($urandom_range(0, 98304)) - 16384;
        endcase
    endfunction

    // Random mix: mostly in-frame loads, parameter sets and renders, some noise
    task automatic random_reqs(int cnt);
        req_t rq;
        int k;
        for (int i = 0; i < cnt; i++) begin
            k = $urandom_range(0, 99);
            rq = '{cmd: CMD_RENDER, layer: 2'($urandom), x: 6'($urandom), y: 6'($urandom),
                   pixel: $urandom, sel: 3'($urandom), val: $urandom};
            if (k < 30) begin
                rq.cmd = CMD_LOAD;
                if (k < 26) begin
                    rq.x = $urandom_range(0, frame_w() - 1);
                    rq.y = $urandom_range(0, frame_h() - 1);
                end
            end else if (k < 45) begin
                rq.cmd = CMD_PARAM;
                if (k < 43) rq.sel = $urandom_range(0, 5);
                rq.val = rand_value(rq.sel);
            end else if (k < 96) begin
                if (k < 80) begin
                    rq.x = $urandom_range(0, frame_w() - 1);
                    rq.y = $urandom_range(0, frame_h() - 1);
                end
            end else begin
                rq.cmd = CMD_NOP;
            end
            issue(rq);
        end
    endtask

    task automatic wait_idle();
        while (req_q.size() != 0 || i_in_valid || pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [6:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        case (idx)
            REG_COUNT:  cfg_count = data[2:0];
            REG_ENABLE: cfg_enable = data[3:0];
            REG_WIDTH:  cfg_width = data;
            default:    cfg_height = data;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic setup(int cnt, int en, int w, int h, int idle, int stall);
        wait_idle();
        cfg_write(REG_COUNT, 7'(cnt));
        cfg_write(REG_ENABLE, 7'(en));
        cfg_write(REG_WIDTH, 7'(w));
        cfg_write(REG_HEIGHT, 7'(h));
        idle_pct = idle;
        stall_pct = stall;
    endtask

    task automatic mk(logic [1:0] c, logic [1:0] l, logic [5:0] x, logic [5:0] y,
                      logic [31:0] p, logic [2:0] s, logic signed [31:0] v);
        issue('{cmd: c, layer: l, x: x, y: y, pixel: p, sel: s, val: v});
    endtask

    // Stimulus
    initial begin
        for (int i = 0; i < LAYERS; i++) begin
            sc_x[i] = Q_ONE; sc_y[i] = Q_ONE; of_x[i] = 0; of_y[i] = 0;
            cos_q[i] = 16384; sin_q[i] = 0; opac[i] = Q_ONE;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no layers, corners, every selector, rotation folds, bad codes
        mk(CMD_RENDER, 0, 0, 0, 0, 0, 0);
        wait_idle();
        cfg_write(REG_COUNT, 7'd4);
        mk(CMD_LOAD, 0, 0, 0, 32'h0000_0000, 0, 0);
        mk(CMD_LOAD, 3, 63, 63, 32'hFFFF_FFFF, 0, 0);
        mk(CMD_LOAD, 1, 63, 0, 32'h80FF_00FF, 0, 0);
        mk(CMD_RENDER, 0, 63, 63, 0, 0, 0);
        mk(CMD_RENDER, 0, 0, 0, 0, 0, 0);
        mk(CMD_PARAM, 0, 0, 0, 0, SEL_SCALE_X, 32'sh0000_8000);
        mk(CMD_PARAM, 1, 0, 0, 0, SEL_SCALE_Y, 32'sh0002_0000);
        mk(CMD_PARAM, 2, 0, 0, 0, SEL_OFFSET_X, -32'sh0005_0000);
        mk(CMD_PARAM, 3, 0, 0, 0, SEL_OFFSET_Y, 32'sh0003_0000);
        mk(CMD_PARAM, 0, 0, 0, 0, SEL_ROTATION, 90 * 65536);
        mk(CMD_PARAM, 1, 0, 0, 0, SEL_ROTATION, 180 * 65536);
        mk(CMD_PARAM, 2, 0, 0, 0, SEL_ROTATION, -135 * 65536);
        mk(CMD_PARAM, 3, 0, 0, 0, SEL_ROTATION, 32'sh7FFF_FFFF);
        mk(CMD_PARAM, 3, 0, 0, 0, SEL_ROTATION, 32'sh8000_0000);
        mk(CMD_PARAM, 1, 0, 0, 0, SEL_OPACITY, 0);
        mk(CMD_PARAM, 2, 0, 0, 0, SEL_OPACITY, -32'sh0001_0000);
        mk(CMD_PARAM, 0, 0, 0, 0, SEL_OPACITY, 32'sh0003_0000);
        mk(CMD_PARAM, 0, 0, 0, 0, SEL_SPARE0, 32'sh1234_5678);
        mk(CMD_PARAM, 0, 0, 0, 0, SEL_SPARE1, 32'sh1234_5678);
        mk(CMD_NOP, 3, 63, 63, 32'hFFFF_FFFF, 3'd7, -1);
        mk(CMD_RENDER, 0, 5, 5, 0, 0, 0);
        mk(CMD_RENDER, 0, 63, 0, 0, 0, 0);
        mk(CMD_RENDER, 0, 0, 63, 0, 0, 0);

        // Random phases across settings and idling patterns
        setup(4, 15, 64, 64, 0, 0);       random_reqs(170);
        setup(3, 11, 16, 8, 46, 0);       random_reqs(170);
        setup(7, 15, 1, 1, 0, 46);        random_reqs(150);
        setup(4, 5, 64, 64, 31, 31);      random_reqs(170);
        setup(0, 0, 0, 127, 0, 0);        random_reqs(60);
        setup(2, 3, 8, 8, 0, 0);
        hold_req = 1;
        random_reqs(170);
        setup(4, 15, 32, 32, 31, 31);
        random_reqs(100);
        wait_idle();
        random_reqs(100);
        setup(1, 1, 64, 1, 46, 46);       random_reqs(110);

        wait_idle();
        $display("Run covered %0d requests and %0d composited pixels over 8 settings,",
                 n_req, n_pix);
        $display("including idle gaps, stalls, a long output hold and a drained pause.");
        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (req_q.size() != 0 && $urandom_range(1, 100) > idle_pct) begin
                req_t rq;
                rq = req_q.pop_front();
                i_cmd <= rq.cmd;
                i_layer <= rq.layer;
                i_x <= rq.x;
                i_y <= rq.y;
                i_pixel <= rq.pixel;
                i_param_select <= rq.sel;
                i_param_value <= rq.val;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        in_took = 0;
    end

    // Output stall, with a single long hold when requested
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = 600;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(1, 100) <= stall_pct);
        end
    end

    task automatic report(string what, int got, int want);
        $display("mismatch on pixel %0d: %s got %0d expected %0d", n_pix, what, got, want);
        err_cnt++;
    endtask

    // Monitor: acceptance and result compare
    always @(posedge i_clk) begin
        cycles++;
        if (i_in_valid && !o_in_stall) begin
            in_took = 1;
            n_req++;
        end
        if (o_out_valid && !i_out_stall) begin
            if (pixel_q.size() == 0) begin
                $display("unexpected pixel result at cycle %0d", cycles);
                err_cnt++;
            end else begin
                rgba_t e;
                e = pixel_q.pop_front();
                if (o_out_r !== e.r) report("red", o_out_r, e.r);
                if (o_out_g !== e.g) report("green", o_out_g, e.g);
                if (o_out_b !== e.b) report("blue", o_out_b, e.b);
                if (o_out_a !== e.a) report("alpha", o_out_a, e.a);
            end
            n_pix++;
        end
        if (cycles >= CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

@@ filelist.f @@
rtl/alc_pkg.sv
rtl/alc_ctrl.sv
rtl/alc_datapath.sv
rtl/affine_layer_compositor.sv
verif/tb_top.sv
